// ===== rtl/mlqs_pkg.sv =====
package mlqs_pkg;

   // Size of the scheduler.
   localparam int LEVELS      = 8;
   localparam int QUEUE_DEPTH = 16;

   // Derived widths.
   localparam int LVL_W     = $clog2(LEVELS);
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int USE_W     = $clog2(LEVELS + 1);
   localparam int SLOTS     = LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(SLOTS);
   localparam int ID_W      = 8;
   localparam int PRIO_W    = 8;
   localparam int OUT_LVL_W = 6;
   localparam int STATUS_W  = 2;

   // Operation codes.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   // Request beat.
   typedef struct packed {
      logic              opcode;
      logic [ID_W-1:0]   proc_id;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ID_W-1:0]      out_proc_id;
      logic [OUT_LVL_W-1:0] out_level;
   } rsp_type;

   // Per-level queue descriptor.
   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [CNT_W-1:0] count;
   } meta_type;

   // Write port of the descriptor memory.
   typedef struct packed {
      logic             en;
      logic [LVL_W-1:0] addr;
      meta_type         data;
   } meta_wr_type;

   // Write port of the slot memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   data;
   } store_wr_type;

endpackage

// ===== rtl/mlqs_meta.sv =====
module mlqs_meta import mlqs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [LVL_W-1:0] rd_addr,
   input  meta_wr_type      wr,
   output meta_type         rd_data
);

   meta_type         mem [LEVELS];
   meta_type         data_ff;
   logic             rd_valid_ff;
   logic [LEVELS-1:0] valid_ff;

   // Descriptor storage; one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         data_ff     <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // An entry never written since reset reads as an empty queue at slot zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? data_ff : '0;

endmodule

// ===== rtl/mlqs_store.sv =====
module mlqs_store import mlqs_pkg::*; (
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ID_W-1:0]   rd_data
);

   logic [ID_W-1:0] mem [SLOTS];
   logic [ID_W-1:0] rd_data_ff;

   // Process id slots of all levels, one write and one registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/multilevel_queue_slot_scheduler.sv =====
// Channel   Ports                        Handshake
// request   start, busy, req_data        beat taken when start is high and busy is low
// response  rsp_valid, rsp_data          beat shown for one cycle, always taken
//
// An enqueue keeps busy high through the update step after the request beat, a dequeue
// through the update and pop steps (update alone when every level is empty): the
// descriptor memory read feeds the update step and the slot memory read the pop step.
// The response beat is shown in the first cycle with busy low again.
// Reset is synchronous; it empties every level and clears the usage counters at once.
// The response channel cannot stall, so nothing waits on the receiver.
module multilevel_queue_slot_scheduler import mlqs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_POP    = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic              is_deq_ff, is_deq_in;
   logic              found_ff, found_in;
   logic              clear_ff, clear_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [ID_W-1:0]   pid_ff, pid_in;
   logic [LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [LEVELS-1:0] full_ff, full_in;
   logic [USE_W-1:0]  used_ff [LEVELS];
   logic [USE_W-1:0]  used_in [LEVELS];
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic [LEVELS-1:0] elig;
   logic [LVL_W-1:0]  pick_first, pick_any, req_lvl;
   logic              have_first, have_any;

   meta_type          meta_rd;
   meta_wr_type       meta_wr;
   store_wr_type      store_wr;
   logic              store_rd_en;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [ID_W-1:0]   store_rd_data;
   logic [CNT_W:0]    tail_sum;
   logic [PTR_W-1:0]  tail_ptr, head_next;
   logic [CNT_W-1:0]  count_up, count_down;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] level,
                                                   input logic [PTR_W-1:0] ptr);
      slot_addr = ADDR_W'(level) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
   endfunction

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A level qualifies when it holds work and is still under its quota.
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         elig[l] = nonempty_ff[l] && (used_ff[l] < USE_W'(LEVELS - l));
      end
   end

   // First qualifying level, and first non-empty level for the retry round.
   always_comb begin
      pick_first = '0;
      have_first = 1'b0;
      pick_any   = '0;
      have_any   = 1'b0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (elig[l]) begin
            pick_first = LVL_W'(l);
            have_first = 1'b1;
         end
         if (nonempty_ff[l]) begin
            pick_any = LVL_W'(l);
            have_any = 1'b1;
         end
      end
   end

   // Level addressed by the incoming beat.
   always_comb begin
      if (req_data.opcode == OP_ENQUEUE) begin
         if (req_data.priority_req >= PRIO_W'(LEVELS)) begin
            req_lvl = LVL_W'(LEVELS - 1);
         end else begin
            req_lvl = LVL_W'(req_data.priority_req);
         end
      end else if (have_first) begin
         req_lvl = pick_first;
      end else if (have_any) begin
         req_lvl = pick_any;
      end else begin
         req_lvl = '0;
      end
   end

   // Ring pointer arithmetic on the descriptor read back from memory.
   always_comb begin
      tail_sum = (CNT_W + 1)'(meta_rd.head) + (CNT_W + 1)'(meta_rd.count);
      if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         tail_ptr = PTR_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH));
      end else begin
         tail_ptr = PTR_W'(tail_sum);
      end
      if (meta_rd.head == PTR_W'(QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = meta_rd.head + 1'b1;
      end
      count_up   = meta_rd.count + 1'b1;
      count_down = meta_rd.count - 1'b1;
   end

   // Sequencer: take the beat, update the level, then fetch the popped id.
   always_comb begin
      state_in      = state_ff;
      is_deq_in     = is_deq_ff;
      found_in      = found_ff;
      clear_in      = clear_ff;
      lvl_in        = lvl_ff;
      pid_in        = pid_ff;
      nonempty_in   = nonempty_ff;
      full_in       = full_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      meta_wr       = '0;
      store_wr      = '0;
      store_rd_en   = 1'b0;
      store_rd_addr = slot_addr(lvl_ff, meta_rd.head);
      for (int l = 0; l < LEVELS; l++) begin
         used_in[l] = used_ff[l];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_UPDATE;
               is_deq_in = req_data.opcode == OP_DEQUEUE;
               pid_in    = req_data.proc_id;
               lvl_in    = req_lvl;
               found_in  = (req_data.opcode == OP_DEQUEUE) && (have_first || have_any);
               clear_in  = (req_data.opcode == OP_DEQUEUE) && !have_first;
            end
         end
         ST_UPDATE: begin
            if (!is_deq_ff) begin
               state_in         = ST_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_in.out_proc_id = '0;
               rsp_in.out_level = OUT_LVL_W'(lvl_ff);
               if (full_ff[lvl_ff]) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status        = STATUS_ENQUEUED;
                  store_wr.en          = 1'b1;
                  store_wr.addr        = slot_addr(lvl_ff, tail_ptr);
                  store_wr.data        = pid_ff;
                  meta_wr.en           = 1'b1;
                  meta_wr.addr         = lvl_ff;
                  meta_wr.data.head    = meta_rd.head;
                  meta_wr.data.count   = count_up;
                  nonempty_in[lvl_ff]  = 1'b1;
                  full_in[lvl_ff]      = count_up == CNT_W'(QUEUE_DEPTH);
               end
            end else begin
               // Usage counters restart when no level qualified in the first round.
               for (int l = 0; l < LEVELS; l++) begin
                  used_in[l] = (clear_ff ? '0 : used_ff[l])
                             + USE_W'(found_ff && (lvl_ff == LVL_W'(l)));
               end
               if (found_ff) begin
                  state_in            = ST_POP;
                  store_rd_en         = 1'b1;
                  meta_wr.en          = 1'b1;
                  meta_wr.addr        = lvl_ff;
                  meta_wr.data.head   = head_next;
                  meta_wr.data.count  = count_down;
                  nonempty_in[lvl_ff] = count_down != '0;
                  full_in[lvl_ff]     = 1'b0;
               end else begin
                  state_in           = ST_IDLE;
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = STATUS_EMPTY;
                  rsp_in.out_proc_id = '0;
                  rsp_in.out_level   = '0;
               end
            end
         end
         ST_POP: begin
            state_in           = ST_IDLE;
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STATUS_DEQUEUED;
            rsp_in.out_proc_id = store_rd_data;
            rsp_in.out_level   = OUT_LVL_W'(lvl_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nonempty_ff  <= '0;
         full_ff      <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            used_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nonempty_ff  <= nonempty_in;
         full_ff      <= full_in;
         for (int l = 0; l < LEVELS; l++) begin
            used_ff[l] <= used_in[l];
         end
      end
   end

   // Payload registers of the item in flight and the response beat.
   always_ff @(posedge clock) begin
      is_deq_ff <= is_deq_in;
      found_ff  <= found_in;
      clear_ff  <= clear_in;
      lvl_ff    <= lvl_in;
      pid_ff    <= pid_in;
      rsp_ff    <= rsp_in;
   end

   mlqs_meta u_meta (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_lvl),
      .wr      (meta_wr),
      .rd_data (meta_rd)
   );

   mlqs_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // A response beat only follows the update or the pop step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_UPDATE || $past(state_ff) == ST_POP))
      else $error("response beat outside an update or pop step");

   // A full level is never marked empty.
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      (full_ff & ~nonempty_ff) == '0)
      else $error("level flagged full and empty");

   // A taken request beat makes the block busy.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request taken without going busy");

   // A pop only targets a level flagged as holding work.
   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && is_deq_ff && found_ff) |-> nonempty_ff[lvl_ff])
      else $error("pop from a level flagged empty");

   // The descriptor of a popped level agrees with its flag.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && is_deq_ff && found_ff) |-> meta_rd.count != '0)
      else $error("pop from a level whose descriptor count is zero");

endmodule
